### design/kts_pkg.sv
package kts_pkg;

  localparam int unsigned NUM_KW = 7;
  localparam int unsigned IQ_DEPTH = 4;
  localparam int unsigned IQ_AW = $clog2(IQ_DEPTH);
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW = $clog2(RQ_DEPTH);

  typedef enum logic [4:0] {
    KIND_SYS     = 5'd0,
    KIND_TYPOSIS = 5'd1,
    KIND_START   = 5'd2,
    KIND_DEF     = 5'd3,
    KIND_RETURN  = 5'd4,
    KIND_ASCII   = 5'd5,
    KIND_PRTLIST = 5'd6,
    KIND_IDENT   = 5'd7,
    KIND_STRING  = 5'd8,
    KIND_NUMBER  = 5'd9,
    KIND_STAR    = 5'd10,
    KIND_AMP     = 5'd11,
    KIND_COLON   = 5'd12,
    KIND_SEMI    = 5'd13,
    KIND_DOLLAR  = 5'd14,
    KIND_PERCENT = 5'd15,
    KIND_END     = 5'd16,
    KIND_ERROR   = 5'd17
  } tok_kind_e;

  // keyword text, first byte in the low bits
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'h0000_0000_0073_7973,
    64'h0073_6973_6f70_7974,
    64'h0000_0074_7261_7473,
    64'h0000_0000_0066_6564,
    64'h0000_6e72_7574_6572,
    64'h0000_0069_6963_7361,
    64'h0074_7369_6c74_7270
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd7, 4'd5, 4'd3, 4'd6, 4'd5, 4'd7
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       zero;
    logic       blank;
    logic       digit;
    logic       numc;
    logic       alpha_us;
    logic       word;
    logic       slash;
    logic       quote;
    logic       sym;
    tok_kind_e  sym_kind;
  } kts_cls_t;

  typedef struct packed {
    tok_kind_e   kind;
    logic [31:0] line;
    logic [31:0] col;
    logic [31:0] off;
    logic [31:0] len;
    logic        last;
  } kts_tok_t;

  function automatic kts_tok_t mk_tok(tok_kind_e k, logic [31:0] l, logic [31:0] c,
                                      logic [31:0] o, logic [31:0] n);
    kts_tok_t t;
    t.kind = k;
    t.line = l;
    t.col  = c;
    t.off  = o;
    t.len  = n;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

### design/kts_front.sv
module kts_front import kts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_byte_i,
  output logic       cls_valid_o,
  output kts_cls_t   cls_o,
  input  logic       cls_pop_i
);

  localparam int unsigned CW = IQ_AW + 1;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_US      = 8'h5f;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_COLON   = 8'h3a;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  function automatic kts_cls_t classify(logic [7:0] c);
    kts_cls_t r;
    logic     alpha;
    alpha      = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    r.ch       = c;
    r.zero     = (c == 8'h00);
    r.blank    = (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0d);
    r.digit    = (c >= 8'h30 && c <= 8'h39);
    r.numc     = r.digit || (c == CH_LOW_X) || (c == CH_UP_X);
    r.alpha_us = alpha || (c == CH_US);
    r.word     = r.alpha_us || r.digit || (c == CH_STAR) || (c == CH_DOLLAR)
                 || (c == CH_AT) || (c == CH_AMP);
    r.slash    = (c == CH_SLASH);
    r.quote    = (c == CH_QUOTE);
    r.sym      = 1'b1;
    unique case (c)
      CH_STAR:    r.sym_kind = KIND_STAR;
      CH_AMP:     r.sym_kind = KIND_AMP;
      CH_COLON:   r.sym_kind = KIND_COLON;
      CH_SEMI:    r.sym_kind = KIND_SEMI;
      CH_DOLLAR:  r.sym_kind = KIND_DOLLAR;
      CH_PERCENT: r.sym_kind = KIND_PERCENT;
      default: begin
        r.sym      = 1'b0;
        r.sym_kind = KIND_ERROR;
      end
    endcase
    return r;
  endfunction

  kts_cls_t         mem_q [IQ_DEPTH];
  logic [IQ_AW-1:0] wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic             wr, rd;

  assign full        = (cnt_q == CW'(IQ_DEPTH));
  assign cls_valid_o = (cnt_q != '0);
  assign cls_o       = mem_q[rp_q];
  assign wr          = push && !full;
  assign rd          = cls_pop_i && cls_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= classify(char_byte_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= IQ_AW'(wp_q + 1'b1);
      if (rd) rp_q <= IQ_AW'(rp_q + 1'b1);
      cnt_q <= CW'(cnt_q + CW'(wr) - CW'(rd));
    end
  end

endmodule

### design/kts_back.sv
module kts_back import kts_pkg::*; #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned KEYWORD_CHARS = 7
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cls_valid_i,
  input  kts_cls_t   cls_i,
  output logic       cls_pop_o,
  input  logic       res_room_i,
  output logic       res_we_o,
  output logic [1:0] res_cnt_o,
  output kts_tok_t   res0_o,
  output kts_tok_t   res1_o
);

  localparam int unsigned KBW = 8 * KEYWORD_CHARS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUM,
    MODE_STR,
    MODE_SLASH,
    MODE_COMMENT
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [COUNT_BITS-1:0] line_q, line_d, col_q, col_d, off_q, off_d;
  logic [COUNT_BITS-1:0] tline_q, tline_d, tcol_q, tcol_d, toff_q, toff_d;
  logic [KBW-1:0]        kbuf_q, kbuf_d, kbuf_app;
  logic                  halt_q, halt_d;

  logic                  step, fall, mv, rst_txt;
  logic [COUNT_BITS-1:0] span, off_adv, line_adv, col_adv;
  logic                  kw_hit;
  tok_kind_e             kw_kind;
  logic                  tok_a_v, tok_b_v;
  kts_tok_t              tok_a, tok_b;
  logic [31:0]           cur_l, cur_c, cur_o, tk_l, tk_c, tk_o, span32;

  assign step      = cls_valid_i && res_room_i;
  assign cls_pop_o = step;
  assign res_we_o  = step;

  assign span     = COUNT_BITS'(off_q - toff_q);
  assign off_adv  = COUNT_BITS'(off_q + CNT_ONE);
  assign line_adv = (cls_i.ch == 8'h0a && line_q != CNT_MAX) ? COUNT_BITS'(line_q + CNT_ONE)
                                                             : line_q;
  assign col_adv  = (cls_i.ch == 8'h0a) ? CNT_ONE
                  : (col_q != CNT_MAX) ? COUNT_BITS'(col_q + CNT_ONE) : col_q;

  assign cur_l  = 32'(line_q);
  assign cur_c  = 32'(col_q);
  assign cur_o  = 32'(off_q);
  assign tk_l   = 32'(tline_q);
  assign tk_c   = 32'(tcol_q);
  assign tk_o   = 32'(toff_q);
  assign span32 = 32'(span);

  always_comb begin
    kbuf_app = kbuf_q;
    for (int j = 0; j < KEYWORD_CHARS; j++) begin
      if (span == COUNT_BITS'(j)) kbuf_app[8*j +: 8] = kbuf_q[8*j +: 8] | cls_i.ch;
    end
  end

  always_comb begin
    kw_hit  = 1'b0;
    kw_kind = KIND_IDENT;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!kw_hit && 32'(KW_LEN[k]) <= KEYWORD_CHARS
          && span == COUNT_BITS'(KW_LEN[k]) && kbuf_q == KW_TEXT[k][KBW-1:0]) begin
        kw_hit  = 1'b1;
        kw_kind = tok_kind_e'(5'(k));
      end
    end
  end

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    off_d   = off_q;
    tline_d = tline_q;
    tcol_d  = tcol_q;
    toff_d  = toff_q;
    kbuf_d  = kbuf_q;
    halt_d  = halt_q;
    fall    = 1'b0;
    mv      = 1'b0;
    rst_txt = 1'b0;
    tok_a_v = 1'b0;
    tok_b_v = 1'b0;
    tok_a   = mk_tok(KIND_ERROR, tk_l, tk_c, tk_o, 32'd0);
    tok_b   = mk_tok(KIND_ERROR, cur_l, cur_c, cur_o, 32'd0);

    if (halt_q) begin
      rst_txt = cls_i.zero;
    end else begin
      unique case (mode_q)
        MODE_WORD: begin
          if (!cls_i.zero && cls_i.word) begin
            kbuf_d = kbuf_app;
            mv     = 1'b1;
          end else begin
            tok_a_v = 1'b1;
            tok_a   = mk_tok(kw_kind, tk_l, tk_c, tk_o, kw_hit ? 32'd0 : span32);
            fall    = 1'b1;
          end
        end
        MODE_NUM: begin
          if (cls_i.numc) begin
            mv = 1'b1;
          end else begin
            tok_a_v = 1'b1;
            tok_a   = mk_tok(KIND_NUMBER, tk_l, tk_c, tk_o, span32);
            fall    = 1'b1;
          end
        end
        MODE_STR: begin
          if (cls_i.zero) begin
            tok_a_v = 1'b1;
            tok_a   = mk_tok(KIND_STRING, tk_l, tk_c, tk_o, span32);
            fall    = 1'b1;
          end else if (cls_i.quote) begin
            tok_a_v = 1'b1;
            tok_a   = mk_tok(KIND_STRING, tk_l, tk_c, tk_o, span32);
            mv      = 1'b1;
            mode_d  = MODE_IDLE;
          end else begin
            mv = 1'b1;
          end
        end
        MODE_SLASH: begin
          if (cls_i.slash) begin
            mv     = 1'b1;
            mode_d = MODE_COMMENT;
          end else begin
            tok_a_v = 1'b1;
            halt_d  = 1'b1;
            rst_txt = cls_i.zero;
          end
        end
        MODE_COMMENT: begin
          if (!cls_i.zero && cls_i.ch != 8'h0a) mv = 1'b1;
          else fall = 1'b1;
        end
        default: fall = 1'b1;
      endcase
    end

    if (fall) begin
      mode_d = MODE_IDLE;
      if (cls_i.zero) begin
        tok_b_v = 1'b1;
        tok_b   = mk_tok(KIND_END, cur_l, cur_c, cur_o, 32'd0);
        rst_txt = 1'b1;
      end else if (cls_i.blank) begin
        mv = 1'b1;
      end else begin
        tline_d = line_q;
        tcol_d  = col_q;
        toff_d  = off_q;
        kbuf_d  = '0;
        if (cls_i.sym) begin
          tok_b_v = 1'b1;
          tok_b   = mk_tok(cls_i.sym_kind, cur_l, cur_c, cur_o, 32'd0);
          mv      = 1'b1;
        end else if (cls_i.slash) begin
          mode_d = MODE_SLASH;
          mv     = 1'b1;
        end else if (cls_i.quote) begin
          mode_d = MODE_STR;
          mv     = 1'b1;
          toff_d = off_adv;
        end else if (cls_i.digit) begin
          mode_d = MODE_NUM;
          mv     = 1'b1;
        end else if (cls_i.alpha_us) begin
          mode_d = MODE_WORD;
          kbuf_d = KBW'(cls_i.ch);
          mv     = 1'b1;
        end else begin
          tok_b_v = 1'b1;
          halt_d  = 1'b1;
        end
      end
    end

    if (mv) begin
      off_d  = off_adv;
      line_d = line_adv;
      col_d  = col_adv;
    end

    if (rst_txt) begin
      mode_d  = MODE_IDLE;
      line_d  = CNT_ONE;
      col_d   = CNT_ONE;
      off_d   = '0;
      tline_d = CNT_ONE;
      tcol_d  = CNT_ONE;
      toff_d  = '0;
      kbuf_d  = '0;
      halt_d  = 1'b0;
    end
  end

  always_comb begin
    res0_o      = tok_a_v ? tok_a : tok_b;
    res0_o.last = !(tok_a_v && tok_b_v);
    res1_o      = tok_b;
    res1_o.last = 1'b1;
    res_cnt_o   = {1'b0, tok_a_v} + {1'b0, tok_b_v};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      line_q  <= CNT_ONE;
      col_q   <= CNT_ONE;
      off_q   <= '0;
      tline_q <= CNT_ONE;
      tcol_q  <= CNT_ONE;
      toff_q  <= '0;
      kbuf_q  <= '0;
      halt_q  <= 1'b0;
    end else if (step) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      off_q   <= off_d;
      tline_q <= tline_d;
      tcol_q  <= tcol_d;
      toff_q  <= toff_d;
      kbuf_q  <= kbuf_d;
      halt_q  <= halt_d;
    end
  end

endmodule

### design/kts_resq.sv
module kts_resq import kts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  logic [1:0] cnt_i,
  input  kts_tok_t   d0_i,
  input  kts_tok_t   d1_i,
  output logic       room_o,
  output logic       empty,
  input  logic       pop,
  output kts_tok_t   head_o
);

  localparam int unsigned CW = RQ_AW + 1;

  kts_tok_t         mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wp_q, rp_q;
  logic [CW-1:0]    cnt_q;
  logic [1:0]       n_wr;
  logic             rd;

  assign n_wr   = we_i ? cnt_i : 2'd0;
  assign rd     = pop && !empty;
  assign empty  = (cnt_q == '0);
  assign room_o = (cnt_q <= CW'(RQ_DEPTH - 2));
  assign head_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) mem_q[wp_q] <= d0_i;
    if (n_wr == 2'd2) mem_q[RQ_AW'(wp_q + 1'b1)] <= d1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= RQ_AW'(wp_q + RQ_AW'(n_wr));
      if (rd) rp_q <= RQ_AW'(rp_q + 1'b1);
      cnt_q <= CW'(cnt_q + CW'(n_wr) - CW'(rd));
    end
  end

endmodule

### design/keyword_token_scanner.sv
// channel   direction  handshake          payload
// source    in         push / full        char_byte_i
// tokens    out        empty / pop        token_kind_o start_line_o start_column_o
//                                         start_offset_o value_length_o last_of_run_o
//
// one byte accepted per cycle unless full; a token reaches the outputs via the byte
// queue and the token queue, and the output side drains one token per cycle on pop
// the scanner takes a byte from its 4-entry byte queue when the 4-entry token
// queue has two free slots, so bytes giving two tokens slow it only if sustained
// full rises when four bytes wait; pop stalls back up through both queues
// reset clears both queues and puts the scanner at line 1, column 1, offset 0
module keyword_token_scanner import kts_pkg::*; #(
  parameter int unsigned COUNT_BITS    = 32,
  parameter int unsigned KEYWORD_CHARS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  token_kind_o,
  output logic [31:0] start_line_o,
  output logic [31:0] start_column_o,
  output logic [31:0] start_offset_o,
  output logic [31:0] value_length_o,
  output logic        last_of_run_o
);

  logic       cls_valid, cls_pop, res_room, res_we;
  logic [1:0] res_cnt;
  kts_cls_t   cls;
  kts_tok_t   res0, res1, head;

  kts_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .char_byte_i (char_byte_i),
    .cls_valid_o (cls_valid),
    .cls_o       (cls),
    .cls_pop_i   (cls_pop)
  );

  kts_back #(
    .COUNT_BITS    (COUNT_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (cls_valid),
    .cls_i       (cls),
    .cls_pop_o   (cls_pop),
    .res_room_i  (res_room),
    .res_we_o    (res_we),
    .res_cnt_o   (res_cnt),
    .res0_o      (res0),
    .res1_o      (res1)
  );

  kts_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (res_we),
    .cnt_i  (res_cnt),
    .d0_i   (res0),
    .d1_i   (res1),
    .room_o (res_room),
    .empty  (empty),
    .pop    (pop),
    .head_o (head)
  );

  assign token_kind_o   = head.kind;
  assign start_line_o   = head.line;
  assign start_column_o = head.col;
  assign start_offset_o = head.off;
  assign value_length_o = head.len;
  assign last_of_run_o  = head.last;

endmodule

### tb/sv/keyword_token_scanner_test.sv
module keyword_token_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned BYTES_PER_PHASE = 400;
  localparam int unsigned KEYWORD_CHARS = 7;
  localparam int unsigned HOLD_OFF_LEN = 150;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2f;

  class token_tracker;
    typedef enum logic [2:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_STR, SCAN_SLASH, SCAN_COMMENT
    } scan_e;

    string kw_words[NUM_KW] = '{"sys", "typosis", "start", "def", "return", "ascii",
                                "prtlist"};
    kts_tok_t expected_tokens[$];
    kts_tok_t step_tokens[$];
    int unsigned bad_tokens;
    scan_e mode;
    logic [31:0] line_no, col_no, offs;
    logic [31:0] tok_line, tok_col, tok_off;
    logic [55:0] kw_buf;
    bit halted;

    function new();
      bad_tokens = 0;
      restart();
    endfunction

    function void restart();
      mode = SCAN_IDLE;
      line_no = 1;
      col_no = 1;
      offs = 0;
      tok_line = 1;
      tok_col = 1;
      tok_off = 0;
      kw_buf = '0;
      halted = 1'b0;
    endfunction

    function void advance(logic [7:0] c);
      offs++;
      if (c == CH_NL) begin
        if (line_no != '1) line_no++;
        col_no = 1;
      end else if (col_no != '1) begin
        col_no++;
      end
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_word(logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_" || c == "*" || c == "$" ||
             c == "@" || c == "&";
    endfunction

    function bit symbol_of(logic [7:0] c, output tok_kind_e k);
      k = KIND_ERROR;
      case (c)
        "*": k = KIND_STAR;
        "&": k = KIND_AMP;
        ":": k = KIND_COLON;
        ";": k = KIND_SEMI;
        "$": k = KIND_DOLLAR;
        "%": k = KIND_PERCENT;
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void emit(tok_kind_e k, logic [31:0] ln, logic [31:0] cl, logic [31:0] of,
                       logic [31:0] nb);
      kts_tok_t t;
      t.kind = k;
      t.line = ln;
      t.col = cl;
      t.off = of;
      t.len = nb;
      t.last = 1'b0;
      step_tokens.push_back(t);
    endfunction

    function void emit_word();
      logic [31:0] len;
      logic [55:0] kw_bits;
      len = offs - tok_off;
      for (int k = 0; k < NUM_KW; k++) begin
        kw_bits = '0;
        for (int i = 0; i < kw_words[k].len(); i++) kw_bits[8*i +: 8] = kw_words[k][i];
        if (len == kw_words[k].len() && kw_words[k].len() <= KEYWORD_CHARS &&
            kw_bits == kw_buf) begin
          emit(tok_kind_e'(KIND_SYS + k), tok_line, tok_col, tok_off, 0);
          return;
        end
      end
      emit(KIND_IDENT, tok_line, tok_col, tok_off, len);
    endfunction

    function void scan_byte(logic [7:0] c);
      logic [31:0] len;
      tok_kind_e sk;
      if (halted) begin
        if (c == CH_NUL) restart();
        return;
      end
      case (mode)
        SCAN_WORD: begin
          if (c != CH_NUL && is_word(c)) begin
            len = offs - tok_off;
            if (len < KEYWORD_CHARS) kw_buf |= 56'(c) << (8 * len);
            advance(c);
            return;
          end
          emit_word();
        end
        SCAN_NUM: begin
          if (is_digit(c) || c == "x" || c == "X") begin
            advance(c);
            return;
          end
          emit(KIND_NUMBER, tok_line, tok_col, tok_off, offs - tok_off);
        end
        SCAN_STR: begin
          if (c == CH_NUL) begin
            emit(KIND_STRING, tok_line, tok_col, tok_off, offs - tok_off);
          end else if (c == CH_QUOTE) begin
            emit(KIND_STRING, tok_line, tok_col, tok_off, offs - tok_off);
            advance(c);
            mode = SCAN_IDLE;
            return;
          end else begin
            advance(c);
            return;
          end
        end
        SCAN_SLASH: begin
          if (c == CH_SLASH) begin
            advance(c);
            mode = SCAN_COMMENT;
            return;
          end
          emit(KIND_ERROR, tok_line, tok_col, tok_off, 0);
          halted = 1'b1;
          if (c == CH_NUL) restart();
          return;
        end
        SCAN_COMMENT: begin
          if (c != CH_NUL && c != CH_NL) begin
            advance(c);
            return;
          end
        end
        default: ;
      endcase

      mode = SCAN_IDLE;
      if (c == CH_NUL) begin
        emit(KIND_END, line_no, col_no, offs, 0);
        restart();
        return;
      end
      if (is_blank(c)) begin
        advance(c);
        return;
      end
      tok_line = line_no;
      tok_col = col_no;
      tok_off = offs;
      kw_buf = '0;
      if (symbol_of(c, sk)) begin
        emit(sk, tok_line, tok_col, tok_off, 0);
        advance(c);
      end else if (c == CH_SLASH) begin
        mode = SCAN_SLASH;
        advance(c);
      end else if (c == CH_QUOTE) begin
        mode = SCAN_STR;
        advance(c);
        tok_off = offs;
      end else if (is_digit(c)) begin
        mode = SCAN_NUM;
        advance(c);
      end else if (is_alpha(c) || c == "_") begin
        mode = SCAN_WORD;
        kw_buf = 56'(c);
        advance(c);
      end else begin
        emit(KIND_ERROR, tok_line, tok_col, tok_off, 0);
        halted = 1'b1;
      end
    endfunction

    // returns 0 for a byte dropped after an error
    function bit take_byte(logic [7:0] c);
      bit live;
      kts_tok_t t;
      live = !halted;
      step_tokens.delete();
      scan_byte(c);
      foreach (step_tokens[i]) begin
        t = step_tokens[i];
        t.last = (i == step_tokens.size() - 1);
        expected_tokens.push_back(t);
      end
      return live;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        bad_tokens++;
      end
    endfunction

    function void match_token(kts_tok_t got);
      kts_tok_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual kind %0d line %0d col %0d",
                 $time, got.kind, got.line, got.col);
        bad_tokens++;
        return;
      end
      want = expected_tokens.pop_front();
      compare_field("token_kind", want.kind, got.kind);
      compare_field("start_line", want.line, got.line);
      compare_field("start_column", want.col, got.col);
      compare_field("start_offset", want.off, got.off);
      compare_field("value_length", want.len, got.len);
      compare_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  char_byte_i;
  logic        empty;
  logic        pop;
  logic [4:0]  token_kind_o;
  logic [31:0] start_line_o;
  logic [31:0] start_column_o;
  logic [31:0] start_offset_o;
  logic [31:0] value_length_o;
  logic        last_of_run_o;

  token_tracker tracker;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  hold_off_cycles = 0;
  int unsigned  live_bytes = 0;
  int unsigned  cycle_count = 0;
  logic [7:0]   text_q[$];

  keyword_token_scanner dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_byte_i    (char_byte_i),
    .empty          (empty),
    .pop            (pop),
    .token_kind_o   (token_kind_o),
    .start_line_o   (start_line_o),
    .start_column_o (start_column_o),
    .start_offset_o (start_offset_o),
    .value_length_o (value_length_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : token_sink
    kts_tok_t got;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.kind = tok_kind_e'(token_kind_o);
        got.line = start_line_o;
        got.col = start_column_o;
        got.off = start_offset_o;
        got.len = value_length_o;
        got.last = last_of_run_o;
        tracker.match_token(got);
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99, 0) >= stall_pct);
      end
    end
  end

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] letter();
    return $urandom_range(1, 0) ? 8'($urandom_range(122, 97)) : 8'($urandom_range(90, 65));
  endfunction

  function automatic logic [7:0] word_tail();
    logic [7:0] extra [6] = '{"_", "*", "$", "@", "&", "_"};
    int unsigned r;
    r = $urandom_range(11, 0);
    if (r < 6) return letter();
    if (r < 9) return 8'($urandom_range(57, 48));
    return extra[$urandom_range(5, 0)];
  endfunction

  function automatic void add_string_body();
    logic [7:0] b;
    repeat ($urandom_range(8, 0)) begin
      b = 8'($urandom_range(255, 1));
      if (b == CH_QUOTE) b = "'";
      text_q.push_back(b);
    end
  endfunction

  function automatic void add_gap();
    logic [7:0] blanks [6] = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
    case ($urandom_range(5, 0))
      0, 1: ;
      default: repeat ($urandom_range(3, 1)) text_q.push_back(blanks[$urandom_range(5, 0)]);
    endcase
  endfunction

  function automatic void add_token();
    logic [7:0] syms [6] = '{"*", "&", ":", ";", "$", "%"};
    logic [7:0] b;
    int unsigned r;
    case ($urandom_range(9, 0))
      0, 1, 2: begin
        add_str(tracker.kw_words[$urandom_range(NUM_KW - 1, 0)]);
        if ($urandom_range(7, 0) == 0) text_q.push_back(word_tail());
      end
      3: begin
        text_q.push_back($urandom_range(4, 0) == 0 ? 8'("_") : letter());
        repeat ($urandom_range(9, 0)) text_q.push_back(word_tail());
      end
      4: begin
        text_q.push_back(8'($urandom_range(57, 48)));
        repeat ($urandom_range(6, 0)) begin
          r = $urandom_range(5, 0);
          text_q.push_back(r == 0 ? 8'("x") : r == 1 ? 8'("X") : 8'($urandom_range(57, 48)));
        end
      end
      5: begin
        text_q.push_back(CH_QUOTE);
        add_string_body();
        text_q.push_back(CH_QUOTE);
      end
      6, 7: text_q.push_back(syms[$urandom_range(5, 0)]);
      8: begin
        add_str("//");
        repeat ($urandom_range(6, 0)) begin
          b = 8'($urandom_range(255, 1));
          text_q.push_back(b == CH_NL ? 8'h20 : b);
        end
        text_q.push_back(CH_NL);
      end
      default: text_q.push_back(8'h20);
    endcase
  endfunction

  // mostly well-formed texts, a few broken ones and some pure noise
  function automatic void make_text();
    int unsigned style;
    style = $urandom_range(19, 0);
    text_q.delete();
    if (style == 0) begin
      repeat ($urandom_range(8, 1)) text_q.push_back(8'($urandom_range(255, 0)));
    end else begin
      repeat ($urandom_range(10, 1)) begin
        add_token();
        add_gap();
      end
      case (style)
        1: text_q.insert($urandom_range(text_q.size() - 1, 0), 8'($urandom_range(255, 1)));
        2: text_q.insert($urandom_range(text_q.size() - 1, 0), CH_SLASH);
        3: begin
          text_q.push_back(CH_QUOTE);
          add_string_body();
        end
        default: ;
      endcase
    end
    text_q.push_back(CH_NUL);
  endfunction

  task automatic send_byte(logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    char_byte_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    if (tracker.take_byte(b)) live_bytes++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i]);
  endtask

  initial begin
    int unsigned idle_by_phase [4] = '{0, 88, 0, 32};
    int unsigned stall_by_phase [4] = '{0, 0, 88, 32};
    push = 1'b0;
    char_byte_i = 8'h00;
    rst_ni = 1'b0;
    tracker = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text_q.delete();
    add_str("sys:9X;\"a");
    text_q.push_back(CH_NUL);
    add_str("//c");
    text_q.push_back(CH_NUL);
    add_str("/@");
    text_q.push_back(CH_NUL);
    add_str("@");
    text_q.push_back(CH_NUL);
    text_q.push_back(8'hc0);
    text_q.push_back(CH_NUL);
    add_str("typosisx%");
    text_q.push_back(CH_NUL);
    send_text();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      if (ph == 0 || ph == 3) hold_off_cycles = HOLD_OFF_LEN;
      live_bytes = 0;
      while (live_bytes < BYTES_PER_PHASE) begin
        make_text();
        send_text();
      end
    end
    push <= 1'b0;

    while (tracker.expected_tokens.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.bad_tokens == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
